// ----- rtl/core/orpg_pkg.sv -----
// Shared types and constants for the outlet relay power guard.
// Used by the channel interfaces, the top level and the port checker.
// No dependencies.
package orpg_pkg;

  localparam int TIME_W     = 48;
  localparam int PAR_W      = 24;
  localparam int GAIN_W     = 32;
  localparam int LIMIT_W    = 16;
  localparam int DELAY_W    = 8;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = PAR_W + GAIN_W;
  localparam int LPROD_W    = LIMIT_W + PAR_W;
  localparam int USEC_W     = 20;
  localparam int DLY_PROD_W = DELAY_W + USEC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  // Power checks are held off for this long after a turn-on.
  localparam logic [TIME_W-1:0] BLANK_US = TIME_W'(6000000);
  localparam logic [USEC_W-1:0] US_PER_S = USEC_W'(1000000);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(65536);

  typedef enum logic {
    OP_TICK = 1'b0,
    OP_CMD  = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_NORMAL = 2'd0,
    ST_ALARM  = 2'd1,
    ST_TRIP   = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_ON    = 3'd1,
    EV_OFF   = 3'd2,
    EV_TRIP  = 3'd3,
    EV_UNDER = 3'd4,
    EV_OVER  = 3'd5
  } event_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_BOOT_DELAY = 3'd0,
    CFG_MAX_POWER  = 3'd1,
    CFG_MIN_ALARM  = 3'd2,
    CFG_MAX_ALARM  = 3'd3,
    CFG_POWER_GAIN = 3'd4
  } cfg_index_t;

endpackage

// ----- rtl/core/orpg_if.sv -----
// Valid/ready channel interfaces of the outlet relay power guard:
// input items, result items and configuration writes.
// Depends on orpg_pkg for field widths.
interface orpg_item_if;
  logic                        valid;
  logic                        ready;
  logic                        op;
  logic [orpg_pkg::TIME_W-1:0] time_us;
  logic                        want_on;
  logic                        at_boot;
  logic [orpg_pkg::PAR_W-1:0]  power_par;
  logic [orpg_pkg::PAR_W-1:0]  power_data;

  modport source(output valid, op, time_us, want_on, at_boot, power_par, power_data,
                 input ready);
  modport sink(input valid, op, time_us, want_on, at_boot, power_par, power_data,
               output ready);
endinterface

interface orpg_result_if;
  logic       valid;
  logic       ready;
  logic       relay_on;
  logic [1:0] outlet_status;
  logic [2:0] event_code;
  logic       turn_on_pending;

  modport source(output valid, relay_on, outlet_status, event_code, turn_on_pending,
                 input ready);
  modport sink(input valid, relay_on, outlet_status, event_code, turn_on_pending,
               output ready);
endinterface

interface orpg_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [orpg_pkg::CFG_IDX_W-1:0]  index;
  logic [orpg_pkg::CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/core/outlet_relay_power_guard_unit.sv -----
// Outlet relay power guard: relay state, delayed boot turn-on and power limit checks.
// Depends on orpg_pkg and the channel interfaces in orpg_if.sv.
//
// Usage:
//   item   - one word per tick (meter reading and time) or on/off command.
//   result - one word per accepted item: relay drive, status, event, pending flag.
//   cfg    - register writes by index; always ready. The user must issue writes only
//            while the block is idle; the block itself does not enforce this.
// Result: the item waits in the input register while the multipliers, compares and
// state update settle, and the outcome is loaded into the result register.
// Throughput: one word per cycle while the receiver keeps ready high. The input
// register takes a new word in the same cycle that the result register is emptied.
// Stall: when the receiver holds ready low, the input register takes one more word
// and item.ready drops while both registers hold a word.
// Reset: synchronous; clears both registers, opens the relay, drops any pending
// turn-on, sets status to normal and loads the register defaults
// (gain 1.0 in Q16.16, all limits and the boot delay zero).
module outlet_relay_power_guard_unit (
  input  logic          clk,
  input  logic          rst,
  orpg_item_if.sink     item,
  orpg_result_if.source result,
  orpg_cfg_if.sink      cfg
);

  // Configuration registers.
  logic [orpg_pkg::DELAY_W-1:0] boot_delay_s;
  logic [orpg_pkg::LIMIT_W-1:0] max_power;
  logic [orpg_pkg::LIMIT_W-1:0] min_alarm;
  logic [orpg_pkg::LIMIT_W-1:0] max_alarm;
  logic [orpg_pkg::GAIN_W-1:0]  power_gain;

  // Guard state.
  logic                        relay_closed;
  logic                        pend_valid;
  logic [orpg_pkg::TIME_W-1:0] pend_time;
  logic [orpg_pkg::TIME_W-1:0] last_on_time;
  orpg_pkg::status_t           status_reg;

  // Input register.
  logic                        v1;
  logic                        s1_op;
  logic [orpg_pkg::TIME_W-1:0] s1_time;
  logic                        s1_want;
  logic                        s1_boot;
  logic [orpg_pkg::PAR_W-1:0]  s1_par;
  logic [orpg_pkg::PAR_W-1:0]  s1_data;

  // Result register.
  logic       ov;
  logic       o_relay;
  logic [1:0] o_status;
  logic [2:0] o_event;
  logic       o_pending;

  logic out_free;
  logic s1_free;
  logic s1_go;

  logic [orpg_pkg::DLY_PROD_W-1:0] dly_prod;
  logic [orpg_pkg::TIME_W-1:0]     pend_calc;
  logic [orpg_pkg::PROD_W-1:0]     prod_calc;
  logic [orpg_pkg::LPROD_W-1:0]    q_trip_calc;
  logic [orpg_pkg::LPROD_W-1:0]    q_min_calc;
  logic [orpg_pkg::LPROD_W-1:0]    q_max_calc;
  logic                            data_zero;

  logic                        relay_next;
  logic                        pend_valid_next;
  logic [orpg_pkg::TIME_W-1:0] pend_time_next;
  logic [orpg_pkg::TIME_W-1:0] last_on_next;
  orpg_pkg::status_t           status_next;
  orpg_pkg::event_t            ev;

  assign out_free   = !ov || result.ready;
  assign s1_free    = !v1 || out_free;
  assign s1_go      = v1 && out_free;
  assign item.ready = s1_free;
  assign cfg.ready  = 1'b1;

  // Multipliers: these depend only on the word and the registers, never on state.
  assign dly_prod    = orpg_pkg::DLY_PROD_W'(boot_delay_s)
                     * orpg_pkg::DLY_PROD_W'(orpg_pkg::US_PER_S);
  assign pend_calc   = s1_time + orpg_pkg::TIME_W'(dly_prod);
  assign prod_calc   = orpg_pkg::PROD_W'(s1_par) * orpg_pkg::PROD_W'(power_gain);
  assign q_trip_calc = orpg_pkg::LPROD_W'(max_power) * orpg_pkg::LPROD_W'(s1_data);
  assign q_min_calc  = orpg_pkg::LPROD_W'(min_alarm) * orpg_pkg::LPROD_W'(s1_data);
  assign q_max_calc  = orpg_pkg::LPROD_W'(max_alarm) * orpg_pkg::LPROD_W'(s1_data);
  assign data_zero   = (s1_data == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      boot_delay_s <= '0;
      max_power    <= '0;
      min_alarm    <= '0;
      max_alarm    <= '0;
      power_gain   <= orpg_pkg::GAIN_RESET;
    end else if (cfg.valid) begin
      case (orpg_pkg::cfg_index_t'(cfg.index))
        orpg_pkg::CFG_BOOT_DELAY: boot_delay_s <= cfg.data[orpg_pkg::DELAY_W-1:0];
        orpg_pkg::CFG_MAX_POWER:  max_power    <= cfg.data[orpg_pkg::LIMIT_W-1:0];
        orpg_pkg::CFG_MIN_ALARM:  min_alarm    <= cfg.data[orpg_pkg::LIMIT_W-1:0];
        orpg_pkg::CFG_MAX_ALARM:  max_alarm    <= cfg.data[orpg_pkg::LIMIT_W-1:0];
        orpg_pkg::CFG_POWER_GAIN: power_gain   <= cfg.data[orpg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (s1_free) begin
      v1 <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_op   <= item.op;
      s1_time <= item.time_us;
      s1_want <= item.want_on;
      s1_boot <= item.at_boot;
      s1_par  <= item.power_par;
      s1_data <= item.power_data;
    end
  end

  // Compares and state update. Power is compared against limit*data scaled by
  // 2^16, which avoids the divide.
  always_comb begin
    logic                        trip_hit;
    logic                        under_hit;
    logic                        over_hit;
    logic                        fire;
    logic                        closed_eff;
    logic                        settled;
    logic                        checks_ok;
    logic [orpg_pkg::TIME_W-1:0] last_eff;
    logic [orpg_pkg::TIME_W-1:0] since_on;

    relay_next      = relay_closed;
    pend_valid_next = pend_valid;
    pend_time_next  = pend_time;
    last_on_next    = last_on_time;
    status_next     = status_reg;
    ev              = orpg_pkg::EV_NONE;

    trip_hit  = (max_power != '0) && !data_zero
              && (prod_calc > {q_trip_calc, orpg_pkg::FRAC_W'(0)});
    under_hit = (min_alarm != '0)
              && (data_zero || (prod_calc < {q_min_calc, orpg_pkg::FRAC_W'(0)}));
    over_hit  = (max_alarm != '0) && !data_zero
              && (prod_calc > {q_max_calc, orpg_pkg::FRAC_W'(0)});

    fire       = pend_valid && (s1_time > pend_time);
    closed_eff = relay_closed || fire;
    last_eff   = (fire && !relay_closed) ? s1_time : last_on_time;
    since_on   = s1_time - last_eff;
    settled    = (s1_time > last_eff) && (since_on > orpg_pkg::BLANK_US);
    checks_ok  = settled && (status_reg != orpg_pkg::ST_ALARM);

    if (orpg_pkg::op_t'(s1_op) == orpg_pkg::OP_CMD) begin
      if (s1_want && s1_boot && (boot_delay_s != '0) && !relay_closed) begin
        pend_time_next  = pend_calc;
        pend_valid_next = 1'b1;
      end else begin
        if (s1_want && !relay_closed) begin
          pend_valid_next = 1'b0;
        end
        if (s1_want != relay_closed) begin
          relay_next = s1_want;
          if (s1_want) begin
            last_on_next = s1_time;
            ev           = orpg_pkg::EV_ON;
          end else begin
            ev = orpg_pkg::EV_OFF;
          end
        end
      end
    end else begin
      if (fire) begin
        pend_valid_next = 1'b0;
        relay_next      = 1'b1;
        last_on_next    = last_eff;
        if (!relay_closed) begin
          ev = orpg_pkg::EV_ON;
        end
      end
      if (closed_eff) begin
        if (trip_hit) begin
          if (checks_ok) begin
            status_next = orpg_pkg::ST_TRIP;
            relay_next  = 1'b0;
            ev          = orpg_pkg::EV_TRIP;
          end
        end else if (under_hit) begin
          if (checks_ok) begin
            status_next = orpg_pkg::ST_ALARM;
            ev          = orpg_pkg::EV_UNDER;
          end
        end else if (over_hit) begin
          if (checks_ok) begin
            status_next = orpg_pkg::ST_ALARM;
            ev          = orpg_pkg::EV_OVER;
          end
        end else begin
          status_next = orpg_pkg::ST_NORMAL;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      relay_closed <= 1'b0;
      pend_valid   <= 1'b0;
      pend_time    <= '0;
      last_on_time <= '0;
      status_reg   <= orpg_pkg::ST_NORMAL;
    end else if (s1_go) begin
      relay_closed <= relay_next;
      pend_valid   <= pend_valid_next;
      pend_time    <= pend_time_next;
      last_on_time <= last_on_next;
      status_reg   <= status_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      ov <= 1'b0;
    end else if (out_free) begin
      ov <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      o_relay   <= relay_next;
      o_status  <= status_next;
      o_event   <= ev;
      o_pending <= pend_valid_next;
    end
  end

  assign result.valid           = ov;
  assign result.relay_on        = o_relay;
  assign result.outlet_status   = o_status;
  assign result.event_code      = o_event;
  assign result.turn_on_pending = o_pending;

endmodule

// ----- rtl/core/orpg_checker.sv -----
// Port-level checker for the outlet relay power guard, and its bind to the top level.
// Depends on orpg_pkg for status and event codes.
module orpg_checker (
  input logic       clk,
  input logic       rst,
  input logic       result_valid,
  input logic       result_ready,
  input logic       relay_on,
  input logic [1:0] outlet_status,
  input logic [2:0] event_code,
  input logic       turn_on_pending
);

  // A stalled result word must hold until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid
      && $stable({relay_on, outlet_status, event_code, turn_on_pending}))
    else $error("result word changed while stalled");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !result_valid)
    else $error("result valid right after reset");

  // A trip always leaves the relay open and the status tripped.
  a_trip_opens: assert property (@(posedge clk) disable iff (rst)
    result_valid && (event_code == orpg_pkg::EV_TRIP)
      |-> !relay_on && (outlet_status == orpg_pkg::ST_TRIP))
    else $error("trip event without open relay and tripped status");

  // Alarms are raised only with the relay closed.
  a_alarm_state: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((event_code == orpg_pkg::EV_UNDER) || (event_code == orpg_pkg::EV_OVER))
      |-> relay_on && (outlet_status == orpg_pkg::ST_ALARM))
    else $error("alarm event with wrong relay or status");

  a_on_off: assert property (@(posedge clk) disable iff (rst)
    result_valid && ((event_code == orpg_pkg::EV_ON) || (event_code == orpg_pkg::EV_OFF))
      |-> relay_on == (event_code == orpg_pkg::EV_ON))
    else $error("relay drive disagrees with on/off event");

endmodule

bind outlet_relay_power_guard_unit orpg_checker u_orpg_checker (
  .clk             (clk),
  .rst             (rst),
  .result_valid    (result.valid),
  .result_ready    (result.ready),
  .relay_on        (result.relay_on),
  .outlet_status   (result.outlet_status),
  .event_code      (result.event_code),
  .turn_on_pending (result.turn_on_pending)
);

// ----- tb/tb.sv -----
// Self-checking bench for outlet_relay_power_guard_unit: relay commands, meter ticks and
// register writes go in over valid/ready channels, and every result word is checked
// against an in-bench prediction. Depends on orpg_pkg, orpg_if.sv and the block itself.
`timescale 1ns / 100ps

module tb;
  import orpg_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 3'd7;

  typedef struct packed {
    op_t               op;
    logic [TIME_W-1:0] time_us;
    logic              want_on;
    logic              at_boot;
    logic [PAR_W-1:0]  power_par;
    logic [PAR_W-1:0]  power_data;
  } guard_word_t;

  typedef struct packed {
    logic    relay_on;
    status_t status;
    event_t  ev;
    logic    pending;
  } outcome_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
  } reg_write_t;

  logic clk;
  logic rst;

  orpg_item_if   item_ch();
  orpg_result_if result_ch();
  orpg_cfg_if    cfg_ch();

  outlet_relay_power_guard_unit dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  guard_word_t guard_word_q[$];
  outcome_t    outcome_q[$];
  reg_write_t  reg_write_q[$];

  int words_sent;
  int words_taken;
  int cfg_sent;
  int cfg_taken;
  int fail_count;
  int send_idle_pct;
  int recv_stall_pct;
  int quiet_cycles;
  logic [TIME_W-1:0] clock_us;

  // Predicted state of the outlet and its registers.
  logic               relay_now;
  logic               pend_on;
  logic [TIME_W-1:0]  pend_at;
  logic [TIME_W-1:0]  last_on_at;
  status_t            status_now;
  logic [DELAY_W-1:0] boot_delay;
  logic [LIMIT_W-1:0] trip_limit;
  logic [LIMIT_W-1:0] under_limit;
  logic [LIMIT_W-1:0] over_limit;
  logic [GAIN_W-1:0]  gain_q16;

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op = OP_TICK;
    item_ch.time_us = '0;
    item_ch.want_on = 1'b0;
    item_ch.at_boot = 1'b0;
    item_ch.power_par = '0;
    item_ch.power_data = '0;
    result_ch.ready = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    forever #6 clk = ~clk;
  end

  function automatic event_t move_relay(logic on, logic [TIME_W-1:0] t);
    if (on == relay_now) return EV_NONE;
    relay_now = on;
    if (on) begin
      last_on_at = t;
      return EV_ON;
    end
    return EV_OFF;
  endfunction

  function automatic logic [63:0] scaled_limit(logic [LIMIT_W-1:0] lim, logic [PAR_W-1:0] d);
    return (64'(lim) * 64'(d)) << FRAC_W;
  endfunction

  // Measured power is compared against a limit by cross-multiplying; a zero period reads 0 W.
  function automatic logic power_over(logic [63:0] meas, logic [PAR_W-1:0] d,
                                      logic [LIMIT_W-1:0] lim);
    return d != 0 && meas > scaled_limit(lim, d);
  endfunction

  function automatic outcome_t guard_outcome(guard_word_t w);
    event_t ev;
    event_t unused_ev;
    outcome_t o;
    logic [63:0] meas;
    logic under;
    logic checks_live;
    ev = EV_NONE;
    if (w.op == OP_CMD) begin
      if (w.want_on && w.at_boot && boot_delay != 0 && !relay_now) begin
        pend_at = w.time_us + TIME_W'(boot_delay) * TIME_W'(US_PER_S);
        pend_on = 1'b1;
      end else begin
        if (w.want_on && !relay_now) pend_on = 1'b0;
        ev = move_relay(w.want_on, w.time_us);
      end
    end else begin
      if (pend_on && w.time_us > pend_at) begin
        pend_on = 1'b0;
        ev = move_relay(1'b1, w.time_us);
      end
      if (relay_now) begin
        meas = 64'(w.power_par) * 64'(gain_q16);
        under = (w.power_data == 0) ? 1'b1 : meas < scaled_limit(under_limit, w.power_data);
        checks_live = w.time_us > last_on_at && (w.time_us - last_on_at) > BLANK_US &&
                      status_now != ST_ALARM;
        // The first enabled limit that is exceeded decides, even while checks are held off.
        if (trip_limit != 0 && power_over(meas, w.power_data, trip_limit)) begin
          if (checks_live) begin
            status_now = ST_TRIP;
            unused_ev = move_relay(1'b0, w.time_us);
            ev = EV_TRIP;
          end
        end else if (under_limit != 0 && under) begin
          if (checks_live) begin
            status_now = ST_ALARM;
            ev = EV_UNDER;
          end
        end else if (over_limit != 0 && power_over(meas, w.power_data, over_limit)) begin
          if (checks_live) begin
            status_now = ST_ALARM;
            ev = EV_OVER;
          end
        end else begin
          status_now = ST_NORMAL;
        end
      end
    end
    o.relay_on = relay_now;
    o.status = status_now;
    o.ev = ev;
    o.pending = pend_on;
    return o;
  endfunction

  task automatic check_field(string name, logic [2:0] exp_v, logic [2:0] got_v);
    if (got_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      fail_count++;
    end
  endtask

  // Word driver: a new word is presented once the previous one has been taken.
  always @(posedge clk) begin : word_driver
    guard_word_t w;
    if (rst) begin
      item_ch.valid <= 1'b0;
    end else if (!item_ch.valid || item_ch.ready) begin
      if (guard_word_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        w = guard_word_q.pop_front();
        item_ch.valid <= 1'b1;
        item_ch.op <= w.op;
        item_ch.time_us <= w.time_us;
        item_ch.want_on <= w.want_on;
        item_ch.at_boot <= w.at_boot;
        item_ch.power_par <= w.power_par;
        item_ch.power_data <= w.power_data;
      end else begin
        item_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : reg_driver
    reg_write_t wr;
    if (rst) begin
      cfg_ch.valid <= 1'b0;
    end else if (!cfg_ch.valid || cfg_ch.ready) begin
      if (reg_write_q.size() > 0) begin
        wr = reg_write_q.pop_front();
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= wr.idx;
        cfg_ch.data <= wr.data;
      end else begin
        cfg_ch.valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) result_ch.ready <= 1'b0;
    else result_ch.ready <= $urandom_range(99) >= recv_stall_pct;
  end

  // Checks result words, tracks register writes and predicts each accepted word.
  always @(posedge clk) begin : monitor
    guard_word_t w;
    outcome_t got;
    outcome_t want_o;
    logic moved;
    if (rst) begin
      relay_now = 1'b0;
      pend_on = 1'b0;
      pend_at = '0;
      last_on_at = '0;
      status_now = ST_NORMAL;
      boot_delay = '0;
      trip_limit = '0;
      under_limit = '0;
      over_limit = '0;
      gain_q16 = GAIN_RESET;
    end else begin
      moved = 1'b0;
      if (result_ch.valid && result_ch.ready) begin
        moved = 1'b1;
        got.relay_on = result_ch.relay_on;
        got.status = status_t'(result_ch.outlet_status);
        got.ev = event_t'(result_ch.event_code);
        got.pending = result_ch.turn_on_pending;
        if (outcome_q.size() == 0) begin
          $display("%0t: result word with nothing expected, got %p", $time, got);
          fail_count++;
        end else begin
          want_o = outcome_q.pop_front();
          check_field("relay_on", 3'(want_o.relay_on), 3'(result_ch.relay_on));
          check_field("outlet_status", 3'(want_o.status), 3'(result_ch.outlet_status));
          check_field("event_code", 3'(want_o.ev), result_ch.event_code);
          check_field("turn_on_pending", 3'(want_o.pending), 3'(result_ch.turn_on_pending));
        end
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        moved = 1'b1;
        cfg_taken++;
        case (cfg_ch.index)
          CFG_BOOT_DELAY: boot_delay = cfg_ch.data[DELAY_W-1:0];
          CFG_MAX_POWER:  trip_limit = cfg_ch.data[LIMIT_W-1:0];
          CFG_MIN_ALARM:  under_limit = cfg_ch.data[LIMIT_W-1:0];
          CFG_MAX_ALARM:  over_limit = cfg_ch.data[LIMIT_W-1:0];
          CFG_POWER_GAIN: gain_q16 = cfg_ch.data;
          default: ;
        endcase
      end
      if (item_ch.valid && item_ch.ready) begin
        moved = 1'b1;
        words_taken++;
        w.op = op_t'(item_ch.op);
        w.time_us = item_ch.time_us;
        w.want_on = item_ch.want_on;
        w.at_boot = item_ch.at_boot;
        w.power_par = item_ch.power_par;
        w.power_data = item_ch.power_data;
        outcome_q.push_back(guard_outcome(w));
      end
      quiet_cycles = moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("** outlet_relay_power_guard_unit: FAILED **");
        $finish;
      end
    end
  end

  task automatic queue_word(op_t op, logic [TIME_W-1:0] t, logic want, logic boot,
                            logic [PAR_W-1:0] par, logic [PAR_W-1:0] data);
    guard_word_t w;
    w.op = op;
    w.time_us = t;
    w.want_on = want;
    w.at_boot = boot;
    w.power_par = par;
    w.power_data = data;
    guard_word_q.push_back(w);
    words_sent++;
  endtask

  // Command words carry random meter fields and tick words random command bits.
  task automatic queue_cmd(logic [TIME_W-1:0] t, logic want, logic boot);
    queue_word(OP_CMD, t, want, boot, PAR_W'($urandom()), PAR_W'($urandom()));
  endtask

  task automatic queue_tick(logic [TIME_W-1:0] t, logic [PAR_W-1:0] par,
                            logic [PAR_W-1:0] data);
    queue_word(OP_TICK, t, 1'($urandom()), 1'($urandom()), par, data);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    reg_write_t wr;
    wr.idx = idx;
    wr.data = data;
    reg_write_q.push_back(wr);
    cfg_sent++;
  endtask

  task automatic write_all_regs(logic [DELAY_W-1:0] dly, logic [LIMIT_W-1:0] trip,
                                logic [LIMIT_W-1:0] lo, logic [LIMIT_W-1:0] hi,
                                logic [GAIN_W-1:0] gain);
    write_reg(CFG_BOOT_DELAY, CFG_DATA_W'(dly));
    write_reg(CFG_MAX_POWER, CFG_DATA_W'(trip));
    write_reg(CFG_MIN_ALARM, CFG_DATA_W'(lo));
    write_reg(CFG_MAX_ALARM, CFG_DATA_W'(hi));
    write_reg(CFG_POWER_GAIN, gain);
  endtask

  // Waits until every word has produced its result, then lets the pipeline drain.
  task automatic settle();
    while (words_taken != words_sent || outcome_q.size() != 0 || cfg_taken != cfg_sent)
      @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic step_time();
    if ($urandom_range(3) == 0) clock_us += TIME_W'($urandom_range(5000000, 9000000));
    else clock_us += TIME_W'($urandom_range(0, 2500000));
  endtask

  // Meter reading that usually lands within two counts of one of the limits or of a random one.
  task automatic near_reading(output logic [PAR_W-1:0] par, output logic [PAR_W-1:0] data);
    logic [LIMIT_W-1:0] lim;
    logic [63:0] target;
    case ($urandom_range(3))
      0: lim = trip_limit;
      1: lim = under_limit;
      2: lim = over_limit;
      default: lim = LIMIT_W'($urandom());
    endcase
    case ($urandom_range(4))
      0: data = '0;
      1: data = PAR_W'($urandom_range(1, 16));
      2: data = PAR_W'($urandom_range(1, 4095));
      default: data = PAR_W'($urandom_range(1, 24'hFFFFFF));
    endcase
    if (gain_q16 == 0 || data == 0) begin
      par = PAR_W'($urandom());
    end else begin
      target = scaled_limit(lim, data) / 64'(gain_q16) + 64'($urandom_range(0, 4)) - 64'd2;
      par = (target > 64'hFF_FFFF) ? PAR_W'($urandom()) : target[PAR_W-1:0];
    end
  endtask

  task automatic queue_session();
    logic boot;
    int n;
    logic [PAR_W-1:0] par;
    logic [PAR_W-1:0] data;
    boot = $urandom_range(2) == 0;
    step_time();
    queue_cmd(clock_us, 1'b1, boot);
    // A boot turn-on is released by the first tick strictly after its due time.
    if (boot) clock_us += TIME_W'(boot_delay) * TIME_W'(US_PER_S) +
                          TIME_W'($urandom_range(0, 1));
    n = $urandom_range(2, 12);
    repeat (n) begin
      near_reading(par, data);
      queue_tick(clock_us, par, data);
      step_time();
    end
    if ($urandom_range(2) == 0) queue_cmd(clock_us, 1'b0, 1'($urandom()));
  endtask

  task automatic queue_noise();
    case ($urandom_range(3))
      0: clock_us = TIME_W'({$urandom(), $urandom()});
      1: clock_us -= TIME_W'($urandom_range(0, 1000000));
      default: step_time();
    endcase
    queue_word(op_t'($urandom_range(1)), clock_us, 1'($urandom()), 1'($urandom()),
               PAR_W'($urandom()), ($urandom_range(3) == 0) ? '0 : PAR_W'($urandom()));
  endtask

  task automatic run_phase(int idle_s, int idle_r, int count);
    int target;
    send_idle_pct = idle_s;
    recv_stall_pct = idle_r;
    target = words_sent + count;
    while (words_sent < target) begin
      if ($urandom_range(99) < 85) queue_session();
      else queue_noise();
    end
    settle();
  endtask

  initial begin
    words_sent = 0;
    words_taken = 0;
    cfg_sent = 0;
    cfg_taken = 0;
    fail_count = 0;
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: a boot request with no delay turns on at once.
    queue_cmd(48'd100, 1'b1, 1'b1);
    queue_tick(48'd200, 24'd0, 24'd0);
    queue_cmd(48'd300, 1'b0, 1'b0);
    settle();
    write_all_regs(8'd2, 16'd2000, 16'd100, 16'd1500, GAIN_RESET);
    settle();

    queue_cmd(48'd1000, 1'b0, 1'b0);
    queue_cmd(48'd1000, 1'b1, 1'b1);
    queue_cmd(48'd1500, 1'b1, 1'b1);
    queue_cmd(48'd2000, 1'b0, 1'b0);
    queue_tick(48'd2001500, 24'd5000, 24'd1);
    queue_tick(48'd2001501, 24'd5000, 24'd1);
    queue_tick(48'd3000000, 24'd5000, 24'd1);
    queue_tick(48'd8001502, 24'd5000, 24'd1);
    queue_tick(48'd8001600, 24'd50, 24'd1);
    queue_cmd(48'd8100000, 1'b1, 1'b0);
    queue_tick(48'd14100000, 24'd50, 24'd1);
    queue_tick(48'd14100001, 24'd50, 24'd0);
    queue_tick(48'd15000000, 24'd1600, 24'd1);
    queue_tick(48'd15000001, 24'd1000, 24'd1);
    queue_tick(48'd15000002, 24'd2000, 24'd1);
    queue_tick(48'd15000003, 24'd100, 24'd1);
    queue_tick(48'd14000000, 24'd5000, 24'd1);
    queue_cmd(48'd15000004, 1'b1, 1'b0);
    queue_cmd(48'd15000005, 1'b0, 1'b0);
    queue_cmd(48'd15000010, 1'b1, 1'b1);
    queue_cmd(48'd15000011, 1'b1, 1'b0);
    queue_cmd(48'd15000012, 1'b0, 1'b1);
    // The scheduled time wraps past the top of the time range.
    queue_cmd(48'hFFFF_FFFF_FF00, 1'b1, 1'b1);
    queue_tick(48'hFFFF_FFFF_FFFF, 24'hFFFFFF, 24'hFFFFFF);
    settle();

    clock_us = 48'd30000000;
    write_all_regs(8'd1, 16'd3000, 16'd20, 16'd2500, GAIN_RESET);
    settle();
    run_phase(0, 0, 300);

    write_all_regs(8'hFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    settle();
    run_phase(51, 0, 300);

    write_all_regs(8'd0, 16'd0, 16'd0, 16'd0, 32'd0);
    write_reg(CFG_UNMAPPED, 32'hFFFF_FFFF);
    settle();
    run_phase(0, 51, 300);

    write_all_regs(8'($urandom_range(0, 5)), 16'($urandom()), 16'($urandom_range(0, 1000)),
                   16'($urandom()), 32'($urandom_range(16384, 262144)));
    settle();
    run_phase(29, 29, 300);

    if (fail_count == 0) $display("** outlet_relay_power_guard_unit: PASSED **");
    else $display("** outlet_relay_power_guard_unit: FAILED **");
    $finish;
  end

endmodule
